[hw/rtl/triangle_morton_encoder_unit_defines.svh]
// ----------------------------------------------------------------------------
// triangle morton encoder unit - assertion macros
// shared concurrent assertion shorthands, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_MORTON_ENCODER_UNIT_DEFINES_SVH
`define TRIANGLE_MORTON_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication
`define TMEU_ASSERT_IMP(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) else $error(msg);

// next-cycle implication
`define TMEU_ASSERT_NXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

[hw/rtl/tmeu_pkg.sv]
// ----------------------------------------------------------------------------
// tmeu_pkg
// widths, types and helpers shared by the triangle morton encoder unit
// ----------------------------------------------------------------------------
package tmeu_pkg;

	localparam int COORD_W   = 32;
	localparam int QUANT_W   = 10;
	localparam int AXES      = 3;
	localparam int VERTS     = 3;

	localparam int EXT_W     = COORD_W + 1;
	localparam int OFF_W     = COORD_W + 2;
	localparam int DEN_W     = COORD_W + 2;
	localparam int SUM_W     = COORD_W + 4;
	localparam int NUM_W     = COORD_W + 3 + QUANT_W;
	localparam int POS_W     = NUM_W - QUANT_W;
	localparam int QUO_W     = QUANT_W + 1;
	localparam int STEP_W    = $clog2(QUANT_W + 1);
	localparam int CODE_W    = 3 * QUANT_W;

	localparam int TRI_W     = VERTS * AXES * COORD_W;
	localparam int IN_DATA_W = ((TRI_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((CODE_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 8;

	localparam int TU_CLIP   = 0;
	localparam int TU_DEG    = 1;

	localparam int CFG_IDX_W = 3;
	localparam int SETTLE_W  = 2;
	localparam logic [SETTLE_W-1:0] SETTLE_CYC = SETTLE_W'(3);

	localparam logic [QUANT_W-1:0] QMAX = {QUANT_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MIN_Y = 3'd1,
		REG_BOX_MIN_Z = 3'd2,
		REG_BOX_MAX_X = 3'd3,
		REG_BOX_MAX_Y = 3'd4,
		REG_BOX_MAX_Z = 3'd5
	} cfg_reg_t;

	// one triangle: [vertex][axis], vertex 0 axis x in the lowest bits
	typedef logic [VERTS-1:0][AXES-1:0][COORD_W-1:0] tri_t;

	// derived box values; the user keeps them static while items are in flight
	typedef struct packed {
		logic                         degenerate;
		logic [DEN_W-1:0]             den;
		logic [AXES-1:0][OFF_W-1:0]   off3;
	} derived_t;

	typedef struct packed {
		logic             neg;
		logic [NUM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} axis_t;

	// index 0 x, 1 y, 2 z
	typedef axis_t [AXES-1:0] div_item_t;

	function automatic logic [CODE_W-1:0] interleave3(input logic [QUANT_W-1:0] qx,
		input logic [QUANT_W-1:0] qy, input logic [QUANT_W-1:0] qz);
		logic [CODE_W-1:0] c;
		c = '0;
		for (int k = 0; k < QUANT_W; k++) begin
			c[3*k+2] = qx[k];
			c[3*k+1] = qy[k];
			c[3*k]   = qz[k];
		end
		return c;
	endfunction

endpackage

[hw/rtl/tmeu_cfg.sv]
// ----------------------------------------------------------------------------
// tmeu_cfg
// scene box registers and the short pipeline that derives divisor and offsets
// ----------------------------------------------------------------------------
module tmeu_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tmeu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tmeu_pkg::COORD_W-1:0]   cfg_data,
	output tmeu_pkg::derived_t             derived,
	output logic                           settling
);
	import tmeu_pkg::*;

	logic [COORD_W-1:0]          min_q [AXES];
	logic [COORD_W-1:0]          max_q [AXES];
	logic signed [EXT_W-1:0]     ext_q [AXES];
	logic [OFF_W-1:0]            off3_q [AXES];
	logic signed [EXT_W-1:0]     emax_q;
	logic [DEN_W-1:0]            den_q;
	logic                        deg_q;
	logic [SETTLE_W-1:0]         settle_q;
	logic signed [EXT_W-1:0]     ext_d [AXES];
	logic [EXT_W-1:0]            negmin_d [AXES];
	logic signed [EXT_W-1:0]     emax_d;
	logic                        wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				min_q[a] <= '0;
				max_q[a] <= '0;
			end
		end else if (wr) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BOX_MIN_X: min_q[0] <= cfg_data;
				REG_BOX_MIN_Y: min_q[1] <= cfg_data;
				REG_BOX_MIN_Z: min_q[2] <= cfg_data;
				REG_BOX_MAX_X: max_q[0] <= cfg_data;
				REG_BOX_MAX_Y: max_q[1] <= cfg_data;
				REG_BOX_MAX_Z: max_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// extents and negated minima for the tripled offsets
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			ext_d[a]    = $signed({max_q[a][COORD_W-1], max_q[a]})
				- $signed({min_q[a][COORD_W-1], min_q[a]});
			negmin_d[a] = EXT_W'(0) - {min_q[a][COORD_W-1], min_q[a]};
		end
	end

	always_comb begin
		emax_d = ext_q[0];
		if (ext_q[1] > emax_d) emax_d = ext_q[1];
		if (ext_q[2] > emax_d) emax_d = ext_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				ext_q[a]  <= '0;
				off3_q[a] <= '0;
			end
			emax_q   <= '0;
			den_q    <= '0;
			deg_q    <= 1'b1;
			settle_q <= '0;
		end else begin
			for (int a = 0; a < AXES; a++) begin
				ext_q[a]  <= ext_d[a];
				off3_q[a] <= min_q[a][COORD_W-1]
					? ({1'b0, negmin_d[a]} + {negmin_d[a], 1'b0}) : '0;
			end
			emax_q <= emax_d;
			den_q  <= {1'b0, emax_q} + {emax_q, 1'b0};
			deg_q  <= emax_q[EXT_W-1] || (emax_q == '0);
			if (wr)
				settle_q <= SETTLE_CYC;
			else if (settle_q != '0)
				settle_q <= settle_q - SETTLE_W'(1);
		end
	end

	always_comb begin
		derived.degenerate = deg_q;
		derived.den        = den_q;
		for (int a = 0; a < AXES; a++)
			derived.off3[a] = off3_q[a];
	end

	assign settling = (settle_q != '0);

endmodule

[hw/rtl/tmeu_front.sv]
// ----------------------------------------------------------------------------
// tmeu_front
// three stages: partial sums, full vertex sum, scaling by the quantiser max
// ----------------------------------------------------------------------------
module tmeu_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tmeu_pkg::tri_t        tri_in,
	input  tmeu_pkg::derived_t    derived,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tmeu_pkg::div_item_t   out_item
);
	import tmeu_pkg::*;

	logic                     v_s1, v_s2, v_s3;
	logic                     rdy1, rdy2, rdy3;
	logic signed [SUM_W-1:0]  pa_s1 [AXES];
	logic signed [SUM_W-1:0]  pb_s1 [AXES];
	logic signed [SUM_W-1:0]  sum_s2 [AXES];
	div_item_t                item_s3;
	div_item_t                item_d;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// sum * (2^q - 1) as a shift and subtract; only used when the sum is not negative
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			item_d[a].neg = sum_s2[a][SUM_W-1];
			item_d[a].rem = {sum_s2[a][POS_W-1:0], {QUANT_W{1'b0}}}
				- {{QUANT_W{1'b0}}, sum_s2[a][POS_W-1:0]};
			item_d[a].quo = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			for (int a = 0; a < AXES; a++) begin
				pa_s1[a] <= SUM_W'($signed(tri_in[0][a])) + SUM_W'($signed(tri_in[1][a]));
				pb_s1[a] <= SUM_W'($signed(tri_in[2][a]))
					+ $signed({{(SUM_W-OFF_W){1'b0}}, derived.off3[a]});
			end
		end
		if (v_s1 && rdy2) begin
			for (int a = 0; a < AXES; a++)
				sum_s2[a] <= pa_s1[a] + pb_s1[a];
		end
		if (v_s2 && rdy3)
			item_s3 <= item_d;
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

endmodule

[hw/rtl/tmeu_div_step.sv]
// ----------------------------------------------------------------------------
// tmeu_div_step
// one restoring division stage: resolves one quotient bit on all three axes
// ----------------------------------------------------------------------------
module tmeu_div_step (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tmeu_pkg::STEP_W-1:0] step_bit,
	input  logic [tmeu_pkg::DEN_W-1:0]  den,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  tmeu_pkg::div_item_t         in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output tmeu_pkg::div_item_t         out_item
);
	import tmeu_pkg::*;

	logic             v_s1;
	div_item_t        item_s1;
	div_item_t        item_d;
	logic [NUM_W-1:0] dsh;
	logic             ge;

	assign in_ready = !v_s1 || out_ready;
	assign dsh      = NUM_W'(den) << step_bit;

	always_comb begin
		ge     = 1'b0;
		item_d = in_item;
		for (int a = 0; a < AXES; a++) begin
			ge = (in_item[a].rem >= dsh);
			if (ge) begin
				item_d[a].rem = in_item[a].rem - dsh;
				item_d[a].quo = in_item[a].quo | (QUO_W'(1) << step_bit);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_ready)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= item_d;
	end

	assign out_valid = v_s1;
	assign out_item  = item_s1;

endmodule

[hw/rtl/triangle_morton_encoder_unit.sv]
// ----------------------------------------------------------------------------
// triangle_morton_encoder_unit
// quantises triangle centroids in the scene box and emits 30-bit morton codes
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one triangle per item: nine signed q16.16 coordinates
//   (vertex 0 x,y,z, vertex 1 x,y,z, vertex 2 x,y,z). m_axis returns one
//   item per triangle: the morton code in tdata, clipped and degenerate_box
//   flags in tuser. the cfg channel writes the six scene box registers.
//   from input acceptance to m_axis_tvalid an item passes 3 front stages,
//   11 divider stages and 1 output register. throughput: one item per
//   cycle while m_axis is ready and no box write settles, set by the fully
//   pipelined restoring divider, one quotient bit per stage and axis.
//   after a cfg write s_axis_tready stays low while divisor and offsets
//   are rederived; write cfg only with the pipeline empty.
//   reset clears all valid bits and the box to zero (degenerate box).
//   a stall on m_axis backs up stage by stage; bubbles still close up, so
//   input keeps flowing until every stage holds an item. nothing is lost.
// ----------------------------------------------------------------------------
`include "triangle_morton_encoder_unit_defines.svh"

module triangle_morton_encoder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z
	input  logic [tmeu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// morton_code, zero padding
	output logic [tmeu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// clipped, degenerate_box, zero padding
	output logic [tmeu_pkg::OUT_USER_W-1:0]   m_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tmeu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tmeu_pkg::COORD_W-1:0]      cfg_data
);
	import tmeu_pkg::*;

	localparam int NSTEP = QUANT_W + 1;

	derived_t      derived;
	logic          settling;
	logic          front_in_valid, front_in_ready;
	logic          dv [NSTEP+1];
	logic          dr [NSTEP+1];
	div_item_t     di [NSTEP+1];
	logic          out_rdy;
	logic          m_valid_q;
	logic [CODE_W-1:0] code_q;
	logic          clip_q, deg_q;
	logic [QUANT_W-1:0] qv [AXES];
	logic          clip_d;
	tri_t          tri_in;

	// configuration and derived scale
	tmeu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.derived   (derived),
		.settling  (settling)
	);

	// hold input off while the divisor settles after a write
	assign tri_in         = s_axis_tdata[TRI_W-1:0];
	assign front_in_valid = s_axis_tvalid && !settling;
	assign s_axis_tready  = front_in_ready && !settling;

	tmeu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_in_valid),
		.in_ready  (front_in_ready),
		.tri_in    (tri_in),
		.derived   (derived),
		.out_valid (dv[0]),
		.out_ready (dr[0]),
		.out_item  (di[0])
	);

	// divider chain, most significant quotient bit first; the top bit marks saturation
	for (genvar k = 0; k < NSTEP; k++) begin : g_div
		tmeu_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.step_bit  (STEP_W'(QUANT_W - k)),
			.den       (derived.den),
			.in_valid  (dv[k]),
			.in_ready  (dr[k]),
			.in_item   (di[k]),
			.out_valid (dv[k+1]),
			.out_ready (dr[k+1]),
			.out_item  (di[k+1])
		);
	end

	// clamp each axis: negative sum to zero, quotient past the max to the max
	always_comb begin
		clip_d = 1'b0;
		for (int a = 0; a < AXES; a++) begin
			if (di[NSTEP][a].neg) begin
				qv[a]  = '0;
				clip_d = 1'b1;
			end else if (di[NSTEP][a].quo[QUANT_W]) begin
				qv[a]  = QMAX;
				clip_d = 1'b1;
			end else begin
				qv[a] = di[NSTEP][a].quo[QUANT_W-1:0];
			end
		end
	end

	// output register
	assign out_rdy   = !m_valid_q || m_axis_tready;
	assign dr[NSTEP] = out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_rdy)
			m_valid_q <= dv[NSTEP];
	end

	always_ff @(posedge clk) begin
		if (dv[NSTEP] && out_rdy) begin
			deg_q <= derived.degenerate;
			if (derived.degenerate) begin
				code_q <= '0;
				clip_q <= 1'b0;
			end else begin
				code_q <= interleave3(qv[0], qv[1], qv[2]);
				clip_q <= clip_d;
			end
		end
	end

	always_comb begin
		m_axis_tdata          = '0;
		m_axis_tdata[CODE_W-1:0] = code_q;
		m_axis_tuser          = '0;
		m_axis_tuser[TU_CLIP] = clip_q;
		m_axis_tuser[TU_DEG]  = deg_q;
	end

	assign m_axis_tvalid = m_valid_q;

	`TMEU_ASSERT_IMP(a_deg_gives_zero, m_axis_tvalid && m_axis_tuser[TU_DEG], (m_axis_tdata == '0) && !m_axis_tuser[TU_CLIP], "degenerate box item carries a code or clip flag")
	`TMEU_ASSERT_NXT(a_cfg_blocks_input, cfg_valid && cfg_ready, !s_axis_tready, "input accepted right after a box write")
	`TMEU_ASSERT_IMP(a_settle_blocks_input, settling, !s_axis_tready && !front_in_valid, "input reaches the front while the divisor settles")

endmodule
